// ----- hdl/ppm_pkg.sv -----
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants of the perspective point map
// Coordinate format, matrix constants and stage widths.
// ----------------------------------------------------------------------------
package ppm_pkg;

  // coordinate width, signed, 4 fraction bits
  localparam int COORD_WIDTH = 16;
  // matrix word width and fraction bits
  localparam int MAT_W    = 40;
  localparam int MAT_FRAC = 26;
  // product and sum widths
  localparam int PROD_W = MAT_W + COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  // quotient bits carried with 5 fraction bits (one extra for rounding)
  localparam int QUO_W  = COORD_WIDTH + 1;
  // partial remainder width
  localparam int REM_W  = SUM_W + QUO_W;
  // pipeline depth: two MAC stages, prep, one stage per quotient bit, output
  localparam int LATENCY = 2 + 1 + QUO_W + 1;

  typedef logic signed [MAT_W-1:0]       hcoef_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  // numerators and denominator of one point
  typedef struct packed {
    sum_t num_x;
    sum_t num_y;
    sum_t den;
  } ppm_sums_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  localparam longint SCALE = 64'sd67108864;

  // camera to top view, round to nearest, ties away from zero
  localparam longint H0_0 = (64'sd341575344 * SCALE + 64'sd50000000) / 64'sd100000000;
  localparam longint H0_1 = (64'sd675223255 * SCALE + 64'sd500000000) / 64'sd1000000000;
  localparam longint H0_2 = -((64'sd167839012 * SCALE + 64'sd50000) / 64'sd100000);
  localparam longint H0_3 = -((64'sd148898470 * SCALE + 64'sd500000000) / 64'sd1000000000);
  localparam longint H0_4 = (64'sd653779083 * SCALE + 64'sd50000000) / 64'sd100000000;
  localparam longint H0_5 = -((64'sd193995113 * SCALE + 64'sd50000) / 64'sd100000);
  localparam longint H0_6 =
    -((64'sd100614568 * SCALE + 64'sd50000000000) / 64'sd100000000000);
  localparam longint H0_7 =
    (64'sd505477137 * SCALE + 64'sd50000000000) / 64'sd100000000000;
  localparam longint H0_8 = (64'sd100000000 * SCALE + 64'sd50000000) / 64'sd100000000;

  // top view to camera
  localparam longint H1_0 = (64'sd344314005 * SCALE + 64'sd500000000) / 64'sd1000000000;
  localparam longint H1_1 = -((64'sd192954325 * SCALE + 64'sd500000000) / 64'sd1000000000);
  localparam longint H1_2 = (64'sd203571264 * SCALE + 64'sd500000) / 64'sd1000000;
  localparam longint H1_3 = (64'sd442568546 * SCALE + 64'sd5000000000) / 64'sd10000000000;
  localparam longint H1_4 = (64'sd363836417 * SCALE + 64'sd5000000000) / 64'sd10000000000;
  localparam longint H1_5 = (64'sd144862754 * SCALE + 64'sd500000) / 64'sd1000000;
  localparam longint H1_6 =
    (64'sd122721767 * SCALE + 64'sd500000000000) / 64'sd1000000000000;
  localparam longint H1_7 =
    -((64'sd378051151 * SCALE + 64'sd500000000000) / 64'sd1000000000000);
  localparam longint H1_8 = (64'sd472574244 * SCALE + 64'sd500000000) / 64'sd1000000000;

  localparam hcoef_t HMAT [2][9] = '{
    '{hcoef_t'(H0_0), hcoef_t'(H0_1), hcoef_t'(H0_2),
      hcoef_t'(H0_3), hcoef_t'(H0_4), hcoef_t'(H0_5),
      hcoef_t'(H0_6), hcoef_t'(H0_7), hcoef_t'(H0_8)},
    '{hcoef_t'(H1_0), hcoef_t'(H1_1), hcoef_t'(H1_2),
      hcoef_t'(H1_3), hcoef_t'(H1_4), hcoef_t'(H1_5),
      hcoef_t'(H1_6), hcoef_t'(H1_7), hcoef_t'(H1_8)}
  };

endpackage

// ----- hdl/ppm_if.sv -----
// ----------------------------------------------------------------------------
// ppm_if: request channels of the perspective point map
// Source point channel and mapped point channel, valid/ready.
// ----------------------------------------------------------------------------
interface ppm_in_if import ppm_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   direction;

  modport source (output valid, point_x, point_y, direction, input ready);
  modport sink   (input valid, point_x, point_y, direction, output ready);
endinterface

interface ppm_out_if import ppm_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t mapped_x;
  coord_t mapped_y;
  logic   out_of_range;

  modport source (output valid, mapped_x, mapped_y, out_of_range, input ready);
  modport sink   (input valid, mapped_x, mapped_y, out_of_range, output ready);
endinterface

// ----- hdl/perspective_point_map.sv -----
// ----------------------------------------------------------------------------
// perspective_point_map: 3x3 projective transform of one image point
// Two hard-wired matrices, selected per request by the direction bit.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                | handshake
//  req_i    | in  | point_x, point_y (Q12.4), direction    | valid/ready
//  rsp_o    | out | mapped_x, mapped_y (Q12.4), out_of_rng | valid/ready
//
//  One request per cycle while rsp_o does not stall; each result passes
//  through 2 MAC stages, 1 divider prep stage, 17 quotient-bit stages of
//  the two restoring dividers and 1 rounding/saturation output stage.
//  Reset clears only the stage valid bits; data registers are not reset.
//  A stall on rsp_o freezes the whole pipeline; req_i.ready drops only while
//  the output stage holds a result that is not taken, so nothing is lost or
//  repeated.
// ----------------------------------------------------------------------------
module perspective_point_map import ppm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppm_in_if.sink    req_i,
  ppm_out_if.source rsp_o
);

  // global advance: the last stage is empty or being drained
  logic      adv;
  logic      vld_q [LATENCY];
  ppm_sums_t sums;
  logic      flag_x;
  logic      flag_y;

  assign adv         = !vld_q[LATENCY-1] || rsp_o.ready;
  assign req_i.ready = adv;

  // valid bits ride along with the data stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LATENCY; s++) vld_q[s] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= req_i.valid;
      for (int s = 1; s < LATENCY; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // numerators and denominator, two stages
  ppm_mac u_mac (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (req_i.point_x),
    .y_i    (req_i.point_y),
    .dir_i  (req_i.direction),
    .sums_o (sums)
  );

  // both coordinates share the denominator
  ppm_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (sums.num_x),
    .den_i  (sums.den),
    .res_o  (rsp_o.mapped_x),
    .flag_o (flag_x)
  );

  ppm_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (sums.num_y),
    .den_i  (sums.den),
    .res_o  (rsp_o.mapped_y),
    .flag_o (flag_y)
  );

  assign rsp_o.out_of_range = flag_x || flag_y;
  assign rsp_o.valid        = vld_q[LATENCY-1];

endmodule

// ----- hdl/ppm_mac.sv -----
// ----------------------------------------------------------------------------
// ppm_mac: matrix times (x, y, 1)
// Stage 1 registers the nine products, stage 2 the three row sums.
// ----------------------------------------------------------------------------
module ppm_mac import ppm_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  coord_t    x_i,
  input  coord_t    y_i,
  input  logic      dir_i,
  output ppm_sums_t sums_o
);

  prod_t     prod_q [9];
  prod_t     prod_d [9];
  ppm_sums_t sums_q;
  ppm_sums_t sums_d;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_d[r*3]   = PROD_W'(HMAT[dir_i][r*3])   * PROD_W'(x_i);
      prod_d[r*3+1] = PROD_W'(HMAT[dir_i][r*3+1]) * PROD_W'(y_i);
      // constant term scaled to 4 fraction bits of the coordinates
      prod_d[r*3+2] = PROD_W'(HMAT[dir_i][r*3+2]) <<< 4;
    end
  end

  always_comb begin
    sums_d.num_x = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]);
    sums_d.num_y = SUM_W'(prod_q[3]) + SUM_W'(prod_q[4]) + SUM_W'(prod_q[5]);
    sums_d.den   = SUM_W'(prod_q[6]) + SUM_W'(prod_q[7]) + SUM_W'(prod_q[8]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;

endmodule

// ----- hdl/ppm_div.sv -----
// ----------------------------------------------------------------------------
// ppm_div: pipelined restoring divider with rounding and saturation
// One quotient bit per stage; 5 fraction bits, rounded to 4.
// ----------------------------------------------------------------------------
module ppm_div import ppm_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  sum_t   num_i,
  input  sum_t   den_i,
  output coord_t res_o,
  output logic   flag_o
);

  typedef logic [REM_W-1:0] rem_t;
  typedef logic [QUO_W-1:0] quo_t;

  rem_t rem_q [QUO_W+1];
  rem_t dvs_q [QUO_W+1];
  quo_t quo_q [QUO_W+1];
  logic neg_q [QUO_W+1];
  logic bad_q [QUO_W+1];
  logic ovf_q [QUO_W+1];

  logic [SUM_W-1:0] mag;
  rem_t             dvs;

  assign mag = num_i[SUM_W-1] ? SUM_W'(-num_i) : num_i;
  assign dvs = REM_W'(den_i[SUM_W-2:0]);

  // prep: sign, magnitude, bad denominator, early overflow
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= num_i[SUM_W-1];
      bad_q[0] <= den_i[SUM_W-1] || (den_i == '0);
      ovf_q[0] <= REM_W'(mag) >= (dvs << (COORD_WIDTH - 4));
      dvs_q[0] <= dvs;
      rem_q[0] <= REM_W'(mag) << 5;
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 1; s <= QUO_W; s++) begin : g_step
    localparam int K = QUO_W - s;
    rem_t trial;
    logic ge;

    assign trial = dvs_q[s-1] << K;
    assign ge    = rem_q[s-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? rem_q[s-1] - trial : rem_q[s-1];
        quo_q[s] <= quo_q[s-1] | (QUO_W'(ge) << K);
        dvs_q[s] <= dvs_q[s-1];
        neg_q[s] <= neg_q[s-1];
        bad_q[s] <= bad_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  // round half away from zero, apply sign, clamp
  logic [QUO_W:0]   qinc;
  logic [QUO_W-1:0] val;
  logic [QUO_W-1:0] nval;
  logic             pos_sat;
  logic             neg_sat;
  coord_t           res_d;
  logic             flag_d;
  coord_t           res_q;
  logic             flag_q;

  assign qinc    = {1'b0, quo_q[QUO_W]} + (QUO_W+1)'(1);
  assign val     = qinc[QUO_W:1];
  assign nval    = QUO_W'(0) - val;
  assign pos_sat = ovf_q[QUO_W] || (val > QUO_W'(COORD_MAX));
  assign neg_sat = ovf_q[QUO_W] || (val > (QUO_W'(1) << (COORD_WIDTH - 1)));

  always_comb begin
    if (bad_q[QUO_W]) begin
      res_d  = neg_q[QUO_W] ? COORD_MIN : COORD_MAX;
      flag_d = 1'b1;
    end else if (neg_q[QUO_W]) begin
      res_d  = neg_sat ? COORD_MIN : nval[COORD_WIDTH-1:0];
      flag_d = neg_sat;
    end else begin
      res_d  = pos_sat ? COORD_MAX : val[COORD_WIDTH-1:0];
      flag_d = pos_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      flag_q <= flag_d;
    end
  end

  assign res_o  = res_q;
  assign flag_o = flag_q;

endmodule

// ----- hdl/ppm_checker.sv -----
// ----------------------------------------------------------------------------
// ppm_checker: port-level checks of the perspective point map
// Stall behavior and reset seen on the two request channels.
// ----------------------------------------------------------------------------
module ppm_checker import ppm_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_ready_i,
  input logic   out_valid_i,
  input logic   out_ready_i,
  input coord_t mapped_x_i,
  input coord_t mapped_y_i,
  input logic   out_of_range_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mapped_x_i)
      && $stable(mapped_y_i) && $stable(out_of_range_i))
    else $error("stalled result changed");

  // empty output stage never blocks requests
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request blocked with empty output stage");

  // blocked output freezes the pipeline
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("request taken while output stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid after reset");

endmodule

bind perspective_point_map ppm_checker u_ppm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .mapped_x_i     (rsp_o.mapped_x),
  .mapped_y_i     (rsp_o.mapped_y),
  .out_of_range_i (rsp_o.out_of_range)
);

// ----- tb/sv/ppm_tb_if.sv -----
// ----------------------------------------------------------------------------
// ppm_tb_if: testbench package ppm_tb_pkg, no channel shells of its own
// The RTL interfaces ppm_in_if and ppm_out_if are used directly.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
package ppm_tb_pkg;
  import ppm_pkg::*;

  // one mapped point as the block should deliver it
  typedef struct {
    coord_t mx;
    coord_t my;
    logic   oor;
  } mapped_pt_t;
endpackage

// ----- tb/sv/perspective_point_map_tb.sv -----
// ----------------------------------------------------------------------------
// perspective_point_map_tb: self-checking bench of the perspective point map
// Drives source points with random gaps, stalls the result side at random,
// predicts each mapped point from the matrices and checks it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Scoreboard: predicts the mapped point of each accepted request and
// compares delivered results against the oldest prediction.
class point_map_sb;
  ppm_tb_pkg::mapped_pt_t pending[$];
  int mismatches;
  int checked;
  int saturated;

  // restoring-style quotient of |num|/den, 4 fraction bits, rounded
  static function longint quot_sat(longint num, longint den, ref bit flag);
    longint maxv, minv, mag, q, r, v;
    bit neg;
    maxv = (64'sd1 <<< (ppm_pkg::COORD_WIDTH - 1)) - 1;
    minv = -maxv - 1;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / den;
    r = mag % den;
    if (q > (64'sd1 <<< ppm_pkg::COORD_WIDTH)) q = 64'sd1 <<< ppm_pkg::COORD_WIDTH;
    v = q * 16 + (r * 32 + den) / (2 * den);
    if (neg) v = -v;
    if (v > maxv) begin flag = 1; return maxv; end
    if (v < minv) begin flag = 1; return minv; end
    return v;
  endfunction

  function void note_point(ppm_pkg::coord_t px, ppm_pkg::coord_t py, logic dir);
    longint x, y, n0, n1, dn, h[9];
    ppm_tb_pkg::mapped_pt_t e;
    bit flag;
    x = px;
    y = py;
    for (int i = 0; i < 9; i++) h[i] = ppm_pkg::HMAT[dir][i];
    n0 = h[0] * x + h[1] * y + h[2] * 16;
    n1 = h[3] * x + h[4] * y + h[5] * 16;
    dn = h[6] * x + h[7] * y + h[8] * 16;
    flag = 0;
    if (dn <= 0) begin
      // no division behind the camera plane: sign-directed saturation
      flag = 1;
      e.mx = (n0 >= 0) ? ppm_pkg::COORD_MAX : ppm_pkg::COORD_MIN;
      e.my = (n1 >= 0) ? ppm_pkg::COORD_MAX : ppm_pkg::COORD_MIN;
    end else begin
      e.mx = ppm_pkg::coord_t'(quot_sat(n0, dn, flag));
      e.my = ppm_pkg::coord_t'(quot_sat(n1, dn, flag));
    end
    e.oor = flag;
    pending.push_back(e);
  endfunction

  function void check_result(ppm_pkg::coord_t mx, ppm_pkg::coord_t my, logic oor);
    ppm_tb_pkg::mapped_pt_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result x=%0d y=%0d oor=%b",
                                     mx, my, oor);
      return;
    end
    e = pending.pop_front();
    checked++;
    if (e.oor) saturated++;
    if (mx !== e.mx || my !== e.my || oor !== e.oor) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d exp x=%0d y=%0d oor=%b got x=%0d y=%0d oor=%b",
                 checked, e.mx, e.my, e.oor, mx, my, oor);
    end
  endfunction
endclass

module perspective_point_map_tb;
  import ppm_pkg::*;

  localparam int NUM_RANDOM = 600;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppm_in_if  req_if ();
  ppm_out_if rsp_if ();

  perspective_point_map dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always #5 clk_i = ~clk_i;

  point_map_sb sb = new();
  longint cycles = 0;
  // calm window: no idling on either side
  bit calm = 1'b0;
  int sent = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, checking on every accepted result
  initial rsp_if.ready = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.mapped_x, rsp_if.mapped_y, rsp_if.out_of_range);
      rsp_if.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // send one request; valid held until the handshake, optional random gap first
  task automatic send_point(coord_t px, coord_t py, logic dir);
    if (!calm && $urandom_range(99) < 16) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
      while (!calm && $urandom_range(99) < 16) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.point_x   <= px;
    req_if.point_y   <= py;
    req_if.direction <= dir;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_point(px, py, dir);
    sent++;
  endtask

  // drop valid and wait until every expected result has come
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    coord_t edge_vals[6];
    coord_t px, py;
    req_if.valid = 1'b0;
    req_if.point_x = '0;
    req_if.point_y = '0;
    req_if.direction = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes both ways, origin, typical image points
    edge_vals = '{COORD_MIN, COORD_MAX, 16'sd0, -16'sd1, 16'sd1, 16'sd5120};
    for (int d = 0; d < 2; d++)
      foreach (edge_vals[i])
        send_point(edge_vals[i], edge_vals[(i + 2) % 6], d[0]);
    send_point(16'sd10240, 16'sd7680, 1'b0);
    send_point(16'sd3200, 16'sd2400, 1'b1);
    // hold off until the pipeline is empty
    drain();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= 200 && n < 300);
      if (n == 400) drain();
      if ($urandom_range(3) != 0) begin
        // image-like points: 0..1023 pixels with random fraction
        px = coord_t'($urandom_range(16383));
        py = coord_t'($urandom_range(16383));
      end else begin
        px = coord_t'($urandom());
        py = coord_t'($urandom());
      end
      send_point(px, py, 1'($urandom_range(1)));
    end
    calm = 1'b0;
    drain();
    repeat (2 * LATENCY + 10) @(posedge clk_i);

    $display("Sent %0d points, checked %0d results, %0d flagged out of range",
             sent, sb.checked, sb.saturated);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
